// ----- rtl/speech_energy_extrema_tracker_assert.svh -----
// Assertion macros for the speech energy extrema tracker
`ifndef SPEECH_ENERGY_EXTREMA_TRACKER_ASSERT_SVH
`define SPEECH_ENERGY_EXTREMA_TRACKER_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge outside reset
`define SEET_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("seet assertion failed");

// Next-cycle implication
`define SEET_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("seet assertion failed");

`endif

// ----- rtl/seet_pkg.sv -----
// Shared types, constants and helpers of the speech energy extrema tracker
`default_nettype none
package seet_pkg;

   localparam int E_W    = 41;
   localparam int OFF_W  = 24;
   localparam int MG_W   = 24;
   localparam int WIN_W  = 16;
   localparam int REL_W  = 16;
   localparam int BC_W   = 32;
   localparam int PC_W   = 24;
   localparam int PS_W   = 48;
   localparam int MIXH_W = 42;
   localparam int THR_W  = 58;
   localparam int CSR_W  = 24;
   localparam int RDAT_W = 88;

   localparam logic [1:0] CSR_REL      = 2'd0;
   localparam logic [1:0] CSR_MIN_GAP  = 2'd1;
   localparam logic [1:0] CSR_RATE_WIN = 2'd2;
   localparam logic [1:0] CSR_MAX_WIN  = 2'd3;

   localparam logic [REL_W-1:0] REL_RESET      = 16'd26;
   localparam logic [MG_W-1:0]  MIN_GAP_RESET  = 24'd2205;
   localparam logic [WIN_W-1:0] RATE_WIN_RESET = 16'd430;
   localparam logic [WIN_W-1:0] MAX_WIN_RESET  = 16'd129;

   typedef enum logic [1:0] {
      KIND_NONE   = 2'd0,
      KIND_PEAK   = 2'd1,
      KIND_VALLEY = 2'd2
   } kind_type;

   typedef struct packed {
      logic take_sample;
      logic take_last;
      logic mix;
      logic mul_lo;
      logic mul_hi;
      logic decide;
      logic div_step;
      logic finish;
   } cmd_type;

   typedef struct packed {
      kind_type          kind;
      logic [E_W-1:0]    energy;
      logic [OFF_W-1:0]  offset;
      logic              rate_valid;
      logic [4:0]        rate_bin;
      logic [2:0]        pause_class;
      logic              sentence_end;
      logic              word_end;
      logic [1:0]        word_class;
      logic              volume_valid;
      logic [4:0]        volume_bin;
   } result_type;

   localparam int VOL_N = 19;
   localparam logic [6:0] VOL_TABLE [VOL_N] = '{
      7'd1, 7'd1, 7'd1, 7'd2, 7'd3, 7'd3, 7'd5, 7'd6, 7'd7, 7'd9,
      7'd12, 7'd15, 7'd19, 7'd25, 7'd31, 7'd39, 7'd50, 7'd63, 7'd79
   };

   // Count table entries at or below the energy; the table rises monotonically
   function automatic logic [4:0] vol_bin_f(input logic [E_W-1:0] e);
      logic [4:0] bin;
      bin = '0;
      for (int i = 0; i < VOL_N; i++) begin
         bin = bin + 5'(e >= {34'b0, VOL_TABLE[i]});
      end
      return bin;
   endfunction

endpackage
`default_nettype wire

// ----- rtl/seet_ctrl.sv -----
// Sequencer of the end-of-buffer step and owner of the result handshake
`default_nettype none
module seet_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   input  wire logic              req_tlast,
   output logic                   req_tready,
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   output seet_pkg::cmd_type      cmd
);
   import seet_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE, ST_MIX, ST_MUL_LO, ST_MUL_HI, ST_DECIDE, ST_DIV, ST_DONE
   } state_type;

   state_type  state_ff, state_in;
   logic [4:0] div_cnt_ff, div_cnt_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       slot_free;

   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      div_cnt_in   = div_cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.take_sample = 1'b1;
               cmd.take_last   = req_tlast;
               if (req_tlast) state_in = ST_MIX;
            end
         end
         ST_MIX: begin
            cmd.mix  = 1'b1;
            state_in = ST_MUL_LO;
         end
         ST_MUL_LO: begin
            cmd.mul_lo = 1'b1;
            state_in   = ST_MUL_HI;
         end
         ST_MUL_HI: begin
            cmd.mul_hi = 1'b1;
            state_in   = ST_DECIDE;
         end
         ST_DECIDE: begin
            cmd.decide = 1'b1;
            div_cnt_in = '0;
            state_in   = ST_DIV;
         end
         ST_DIV: begin
            // one remainder bit per cycle, MSB first
            cmd.div_step = 1'b1;
            div_cnt_in   = div_cnt_ff + 5'd1;
            if (div_cnt_ff == 5'd31) state_in = ST_DONE;
         end
         ST_DONE: begin
            // hold until the output register is free
            if (slot_free) begin
               cmd.finish   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         div_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         div_cnt_ff   <= div_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule
`default_nettype wire

// ----- rtl/seet_dp.sv -----
// Datapath: energy accumulation, threshold, extrema search and result register
`default_nettype none
module seet_dp #(
   parameter int SAMPLE_RATE   = 44100,
   parameter int POSITION_BITS = 24
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire seet_pkg::cmd_type             cmd,
   input  wire logic [15:0]                   sample,
   input  wire logic                          csr_we,
   input  wire logic [1:0]                    csr_addr,
   input  wire logic [seet_pkg::CSR_W-1:0]    csr_wdata,
   output seet_pkg::result_type               rsp
);
   import seet_pkg::*;

   localparam int PB = POSITION_BITS;
   localparam int CW = 32;
   localparam int GW = 40;
   localparam logic [GW-1:0] SR1  = GW'(SAMPLE_RATE);
   localparam logic [GW-1:0] SR2  = GW'(2 * SAMPLE_RATE);
   localparam logic [GW-1:0] SR3  = GW'(3 * SAMPLE_RATE);
   localparam logic [GW-1:0] SR4  = GW'(4 * SAMPLE_RATE);
   localparam logic [GW-1:0] SR7  = GW'(7 * SAMPLE_RATE);
   localparam logic [GW-1:0] SR10 = GW'(10 * SAMPLE_RATE);
   localparam logic [PB-1:0] POS_MAX = '1;

   // configuration
   logic [REL_W-1:0] rel_ff;
   logic [MG_W-1:0]  min_gap_ff;
   logic [WIN_W-1:0] rate_win_ff, max_win_ff;

   // tracking state
   logic [E_W-1:0]   energy_acc_ff, prev_e_ff, cand_e_ff, win_peak_ff, e_ff;
   logic             prev_valid_ff, primed_ff;
   logic [PB-1:0]    cand_pos_ff, cur_pos_ff;
   logic [E_W-1:0]   hist_ff [4];
   logic [BC_W-1:0]  bcount_ff, win_start_ff;
   logic [6:0]       syl_win_ff;
   logic [2:0]       syl_word_ff;
   logic [PC_W-1:0]  pcount_ff;
   logic [PS_W-1:0]  psum_ff;

   // step work registers
   logic [MIXH_W-1:0] mixh_ff;
   logic [55:0]       prod_ff;
   logic [36:0]       plo_ff;
   logic [THR_W-1:0]  thr_ff;
   logic [BC_W-1:0]   dividend_ff;
   logic [16:0]       rem_ff;
   result_type        res_ff, rsp_ff;

   assign rsp = rsp_ff;

   // sample path
   logic signed [31:0] sq_s;
   logic [41:0]        acc_sum;
   logic [E_W-1:0]     acc_sat;
   assign sq_s    = $signed(sample) * $signed(sample);
   assign acc_sum = {1'b0, energy_acc_ff} + {10'b0, sq_s};
   assign acc_sat = acc_sum[41] ? '1 : acc_sum[E_W-1:0];

   // threshold mix, newest history entry first
   logic [49:0] mix;
   assign mix = 50'(hist_ff[0]) * 50'd154 + 50'(hist_ff[1]) * 50'd64
              + 50'(hist_ff[2]) * 50'd26 + 50'(hist_ff[3]) * 50'd13;

   logic [36:0] phi;
   logic [THR_W-1:0] thr_sum;
   assign phi     = rel_ff * mixh_ff[41:21];
   assign thr_sum = {phi, 21'b0} + {21'b0, plo_ff};

   // divider for buffer_count mod window
   logic [16:0] mw, rem_sh, rem_nx;
   assign mw     = (max_win_ff == '0) ? 17'd1 : {1'b0, max_win_ff};
   assign rem_sh = {rem_ff[15:0], dividend_ff[BC_W-1]};
   assign rem_nx = (rem_sh >= mw) ? rem_sh - mw : rem_sh;

   // decision
   logic              rising, upd, thr_hit, gaps_ok, acc_evt;
   logic [E_W-1:0]    diff;
   logic [THR_W-1:0]  diff_sh, e_sh;
   logic [CW-1:0]     cpos32, mg32, span32;
   logic [PB-1:0]     span;
   logic [6:0]        syl_n;
   logic [2:0]        sylw_n;
   logic              win_close, rate_ok;
   logic [14:0]       rate_mul;
   logic [GW-1:0]     gap, g10, g2;
   logic              is_pause, sent, word;
   logic [2:0]        pclass;
   logic [59:0]       prod60, psum2;
   logic [PS_W:0]     psum_add;
   logic [BC_W-1:0]   win_dist;
   logic [1:0]        wclass;
   result_type        res;

   assign rising  = !prev_valid_ff || (prev_e_ff <= cand_e_ff);
   assign upd     = rising ? (cand_e_ff <= e_ff) : (cand_e_ff >= e_ff);
   assign diff    = rising ? (cand_e_ff - e_ff) : (e_ff - cand_e_ff);
   assign diff_sh = {9'b0, diff, 8'b0};
   assign thr_hit = diff_sh > thr_ff;
   assign span    = cur_pos_ff - cand_pos_ff;
   assign cpos32  = CW'(cand_pos_ff);
   assign span32  = CW'(span);
   assign mg32    = CW'(min_gap_ff);
   assign gaps_ok = ((cpos32 > mg32) || !prev_valid_ff) && (span32 > mg32);
   assign acc_evt = !upd && thr_hit && gaps_ok;

   assign syl_n     = (syl_win_ff == 7'd127) ? syl_win_ff : syl_win_ff + 7'd1;
   assign sylw_n    = (syl_word_ff == 3'd7) ? syl_word_ff : syl_word_ff + 3'd1;
   assign win_dist  = bcount_ff - win_start_ff;
   assign win_close = win_dist >= BC_W'(rate_win_ff);
   assign rate_ok   = (syl_n >= 7'd1) && (syl_n <= 7'd99);
   assign rate_mul  = syl_n * 8'd205;  // floor(n/5) for every 7-bit n

   assign gap      = GW'(cand_pos_ff);
   assign g10      = gap * GW'(10);
   assign g2       = gap << 1;
   assign is_pause = g10 >= SR1;
   assign prod60   = 60'(prod_ff);
   assign psum2    = {11'b0, psum_ff, 1'b0};
   assign sent     = is_pause && (pcount_ff != '0) && (prod60 >= psum2);
   assign word     = (pcount_ff != '0) && ({prod60[56:0], 3'b0} >= {12'b0, psum_ff});
   assign psum_add = {1'b0, psum_ff} + (PS_W + 1)'(cand_pos_ff);
   assign wclass   = (syl_word_ff == 3'd0) ? 2'd0 :
                     (syl_word_ff > 3'd4)  ? 2'd3 : 2'(syl_word_ff - 3'd1);

   always_comb begin
      if (g10 < SR2)       pclass = 3'd1;
      else if (g10 < SR4)  pclass = 3'd2;
      else if (g10 < SR7)  pclass = 3'd3;
      else if (g10 < SR10) pclass = 3'd4;
      else if (g2 < SR3)   pclass = 3'd5;
      else                 pclass = 3'd6;
   end

   assign e_sh = {9'b0, e_ff, 8'b0};

   always_comb begin
      res = '0;
      if (acc_evt) begin
         res.kind   = rising ? KIND_PEAK : KIND_VALLEY;
         res.energy = cand_e_ff;
         res.offset = (cpos32 > CW'({OFF_W{1'b1}})) ? '1 : OFF_W'(cpos32);
         if (rising) begin
            if (win_close && rate_ok) begin
               res.rate_valid = 1'b1;
               res.rate_bin   = rate_mul[14:10];
            end
         end else begin
            if (is_pause) res.pause_class = pclass;
            res.sentence_end = sent;
            if (word) begin
               res.word_end   = 1'b1;
               res.word_class = wclass;
            end
         end
      end
      if (e_sh > thr_ff) begin
         res.volume_valid = 1'b1;
         res.volume_bin   = vol_bin_f(e_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rel_ff        <= REL_RESET;
         min_gap_ff    <= MIN_GAP_RESET;
         rate_win_ff   <= RATE_WIN_RESET;
         max_win_ff    <= MAX_WIN_RESET;
         energy_acc_ff <= '0;
         prev_e_ff     <= '0;
         prev_valid_ff <= 1'b0;
         cand_e_ff     <= '0;
         cand_pos_ff   <= '0;
         cur_pos_ff    <= '0;
         for (int i = 0; i < 4; i++) hist_ff[i] <= '0;
         primed_ff     <= 1'b0;
         win_peak_ff   <= '0;
         bcount_ff     <= '0;
         syl_win_ff    <= '0;
         win_start_ff  <= '0;
         syl_word_ff   <= '0;
         pcount_ff     <= '0;
         psum_ff       <= '0;
      end else begin
         if (csr_we) begin
            case (csr_addr)
               CSR_REL:      rel_ff      <= csr_wdata[REL_W-1:0];
               CSR_MIN_GAP:  min_gap_ff  <= csr_wdata[MG_W-1:0];
               CSR_RATE_WIN: rate_win_ff <= csr_wdata[WIN_W-1:0];
               CSR_MAX_WIN:  max_win_ff  <= csr_wdata[WIN_W-1:0];
               default:      rel_ff      <= rel_ff;
            endcase
         end
         if (cmd.take_sample) begin
            if (cur_pos_ff != POS_MAX) cur_pos_ff <= cur_pos_ff + PB'(1);
            if (cmd.take_last) begin
               energy_acc_ff <= '0;
               bcount_ff     <= bcount_ff + BC_W'(1);
            end else begin
               energy_acc_ff <= acc_sat;
            end
         end
         if (cmd.decide) begin
            if (e_ff > win_peak_ff) win_peak_ff <= e_ff;
            if (upd) begin
               cand_e_ff   <= e_ff;
               cand_pos_ff <= cur_pos_ff;
            end else if (acc_evt) begin
               prev_e_ff     <= cand_e_ff;
               prev_valid_ff <= 1'b1;
               cand_e_ff     <= e_ff;
               cur_pos_ff    <= span;
               cand_pos_ff   <= span;
               if (rising) begin
                  syl_word_ff <= sylw_n;
                  if (win_close) begin
                     syl_win_ff   <= '0;
                     win_start_ff <= bcount_ff;
                  end else begin
                     syl_win_ff <= syl_n;
                  end
               end else begin
                  if (is_pause) begin
                     if (pcount_ff != '1) pcount_ff <= pcount_ff + PC_W'(1);
                     psum_ff <= psum_add[PS_W] ? '1 : psum_add[PS_W-1:0];
                  end
                  if (word) syl_word_ff <= '0;
               end
            end
         end
         if (cmd.finish) begin
            if (rem_ff == '0) begin
               if (!primed_ff) begin
                  for (int i = 0; i < 4; i++) hist_ff[i] <= win_peak_ff;
                  primed_ff <= 1'b1;
               end else begin
                  hist_ff[3] <= hist_ff[2];
                  hist_ff[2] <= hist_ff[1];
                  hist_ff[1] <= hist_ff[0];
                  hist_ff[0] <= win_peak_ff;
               end
               win_peak_ff <= '0;
            end
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.take_last) begin
         e_ff        <= acc_sat;
         dividend_ff <= bcount_ff + BC_W'(1);
         rem_ff      <= '0;
      end
      if (cmd.mix) begin
         mixh_ff <= mix[49:8];
         prod_ff <= 56'(cand_pos_ff) * 56'(pcount_ff);
      end
      if (cmd.mul_lo) plo_ff <= rel_ff * mixh_ff[20:0];
      if (cmd.mul_hi) thr_ff <= primed_ff ? thr_sum : THR_W'(rel_ff);
      if (cmd.decide) res_ff <= res;
      if (cmd.div_step) begin
         rem_ff      <= rem_nx;
         dividend_ff <= dividend_ff << 1;
      end
      if (cmd.finish) rsp_ff <= res_ff;
   end

endmodule
`default_nettype wire

// ----- rtl/speech_energy_extrema_tracker.sv -----
// Top level of the speech energy extrema tracker
//
//  channel  direction  handshake                 payload
//  req      in         req_tvalid / req_tready   req_tdata sample, req_tlast
//  rsp      out        rsp_tvalid / rsp_tready   rsp_tdata fields, rsp_tuser kind
//  csr      in         csr_valid / csr_ready     csr_addr, csr_wdata
//
// A sample without tlast is accumulated and the block stays ready. A tlast beat
// starts the end-of-buffer step: mix, two threshold multiply halves, decision,
// then a bit-serial remainder of the 32-bit buffer count, then the result load.
// The result load waits while the output register still holds a beat.
// Synchronous active-high reset; the csr channel is always ready.
`default_nettype none
module speech_energy_extrema_tracker #(
   parameter int SAMPLE_RATE   = 44100,
   parameter int POSITION_BITS = 24
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   input  wire logic [15:0]                         req_tdata,  // [15:0] sample
   input  wire logic                                req_tlast,  // last_in_buffer
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // [40:0] extremum_energy, [64:41] extremum_offset, [65] rate_valid,
   // [70:66] rate_bin, [73:71] pause_class, [74] sentence_end, [75] word_end,
   // [77:76] word_class, [78] volume_valid, [83:79] volume_bin, [87:84] zero
   output logic [seet_pkg::RDAT_W-1:0]              rsp_tdata,
   output logic [1:0]                               rsp_tuser,  // [1:0] extremum_kind
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [1:0]                          csr_addr,
   input  wire logic [seet_pkg::CSR_W-1:0]          csr_wdata
);
   import seet_pkg::*;

   cmd_type    cmd;
   result_type rsp;

   assign csr_ready = 1'b1;

   seet_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   seet_dp #(
      .SAMPLE_RATE   (SAMPLE_RATE),
      .POSITION_BITS (POSITION_BITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sample    (req_tdata),
      .csr_we    (csr_valid),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .rsp       (rsp)
   );

   assign rsp_tuser = rsp.kind;
   assign rsp_tdata = {4'b0, rsp.volume_bin, rsp.volume_valid, rsp.word_class,
                       rsp.word_end, rsp.sentence_end, rsp.pause_class, rsp.rate_bin,
                       rsp.rate_valid, rsp.offset, rsp.energy};

`include "speech_energy_extrema_tracker_assert.svh"

   // result load only into a free output register
   `SEET_ASSERT_NOW(a_load_free, cmd.finish, !rsp_tvalid || rsp_tready)
   // a loaded result is presented in the next cycle
   `SEET_ASSERT_NEXT(a_load_shows, cmd.finish, rsp_tvalid)
   // a last beat starts the step, so no beat is taken next cycle
   `SEET_ASSERT_NEXT(a_busy_after_last, req_tvalid && req_tready && req_tlast, !req_tready)

endmodule
`default_nettype wire
